[src/phv_pkg.sv]
// ----------------------------------------------------------------------------
// phv_pkg - shared types and constants for the segment header validator
// Stage records passed down the check pipeline, fault codes, header codes.
// ----------------------------------------------------------------------------
package phv_pkg;

   localparam int WORD_W  = 64;
   localparam int FIELD_W = 32;
   localparam int CODE_W  = 4;

   // Header codes
   localparam logic [FIELD_W-1:0] PT_LOAD = 32'd1;
   localparam int                 PF_X    = 0;   // bit positions in perm_flags
   localparam int                 PF_W    = 1;
   localparam int                 PF_R    = 2;

   // Fault codes, in check order
   localparam logic [CODE_W-1:0] FAULT_NONE        = 4'd0;
   localparam logic [CODE_W-1:0] FAULT_FLAGS       = 4'd1;
   localparam logic [CODE_W-1:0] FAULT_TRUNCATED   = 4'd2;
   localparam logic [CODE_W-1:0] FAULT_EXT_OVF     = 4'd3;
   localparam logic [CODE_W-1:0] FAULT_PAGE_TRUNC  = 4'd4;
   localparam logic [CODE_W-1:0] FAULT_RANGE       = 4'd5;
   localparam logic [CODE_W-1:0] FAULT_WHOLE_SPACE = 4'd6;
   localparam logic [CODE_W-1:0] FAULT_MEM_SHORT   = 4'd7;
   localparam logic [CODE_W-1:0] FAULT_UNREADABLE  = 4'd8;
   localparam logic [CODE_W-1:0] FAULT_PAGE_END    = 4'd9;
   localparam logic [CODE_W-1:0] FAULT_ALIGN       = 4'd10;
   localparam logic [CODE_W-1:0] FAULT_MISALIGNED  = 4'd11;

   // CSR map: one 64-bit register at byte 0
   localparam int                CSR_ADDR_W          = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_SIZE_ADDR = 3'd0;

   // Input beat as seen by the first stage
   typedef struct packed {
      logic [FIELD_W-1:0] seg_type;
      logic [FIELD_W-1:0] perm_flags;
      logic [WORD_W-1:0]  file_offset;
      logic [WORD_W-1:0]  file_bytes;
      logic [WORD_W-1:0]  virt_addr;
      logic [WORD_W-1:0]  mem_bytes;
      logic [WORD_W-1:0]  align_bytes;
   } phv_hdr_type;

   // Stage 1 -> stage 2
   typedef struct packed {
      logic              flags_bad;
      logic              truncated;
      logic              off_gt_lim;
      logic [WORD_W-1:0] lim_minus_off;
      logic [WORD_W-1:0] file_bytes;
      logic [WORD_W-1:0] end_sum;
      logic              msz_nz;
      logic              msz_gt_top;
      logic              va_gt_top;
      logic [WORD_W-1:0] top_minus_msz;
      logic              va_lt_page;
      logic [WORD_W-1:0] lim_minus_va;
      logic [WORD_W-1:0] mem_bytes;
      logic              msz_lt_fsz;
      logic              unreadable;
      logic              ro_load_part;
      logic [WORD_W-1:0] virt_addr;
      logic [WORD_W-1:0] va_xor_off;
      logic [WORD_W-1:0] align_eff;
   } phv_front_type;

   // Stage 2 -> stage 3
   typedef struct packed {
      logic              flags_bad;
      logic              truncated;
      logic              ext_ovf;
      logic [WORD_W-1:0] rounded;
      logic              range_bad;
      logic              whole_space;
      logic              msz_lt_fsz;
      logic              unreadable;
      logic              page_end;
      logic              align_bad;
      logic [WORD_W-1:0] va_xor_off;
      logic [WORD_W-1:0] align_mask;
   } phv_mid_type;

endpackage

[src/program_header_validator.sv]
// ----------------------------------------------------------------------------
// program_header_validator - executable segment header checker
// Three-stage pipeline that checks one segment header per beat against the
// configured image size and page size, and reports the first failed check.
// ----------------------------------------------------------------------------
//
// Usage: a header beat is taken on any cycle with start high; busy is tied
// low, so a new header can enter every cycle. Each header produces exactly
// one result beat, on rsp_valid, in the order taken. The result is shown
// for one cycle only and the receiver cannot stall it, so it must take
// every rsp_valid beat. There are three register stages: stage 1 does the
// flag/truncation checks and all independent 64-bit compares and subtracts,
// stage 2 combines them into extent, range, whole-space, page-end and
// alignment checks and page-rounds the file extent, stage 3 does the
// rounded truncation and offset-alignment tests and picks the first fault.
// image_size lives in a 64-bit CSR at byte offset 0; write it only while
// no header is in flight. PAGE_BYTES must be a power of two (256 to 65536);
// ADDR_BITS (32 to 64) sets the top of the address space. Reset is
// synchronous, active high.
//
module program_header_validator #(
   parameter int PAGE_BYTES = 4096,
   parameter int ADDR_BITS  = 64
) (
   input  logic                              clock,
   input  logic                              reset,

   // header channel
   input  logic                              start,
   output logic                              busy,
   input  logic [phv_pkg::FIELD_W-1:0]       req_seg_type,
   input  logic [phv_pkg::FIELD_W-1:0]       req_perm_flags,
   input  logic [phv_pkg::WORD_W-1:0]        req_file_offset,
   input  logic [phv_pkg::WORD_W-1:0]        req_file_bytes,
   input  logic [phv_pkg::WORD_W-1:0]        req_virt_addr,
   input  logic [phv_pkg::WORD_W-1:0]        req_mem_bytes,
   input  logic [phv_pkg::WORD_W-1:0]        req_align_bytes,

   // result channel
   output logic                              rsp_valid,
   output logic                              rsp_is_valid,
   output logic [phv_pkg::CODE_W-1:0]        rsp_fault_code,

   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [phv_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [phv_pkg::WORD_W-1:0]        csr_pwdata,
   output logic [phv_pkg::WORD_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   logic [phv_pkg::WORD_W-1:0] image_size_reg;
   logic                       hdr_take;
   phv_pkg::phv_hdr_type       hdr;
   logic                       s1_valid;
   phv_pkg::phv_front_type     s1_beat;
   logic                       s2_valid;
   phv_pkg::phv_mid_type       s2_beat;

   // pipeline never backs up: every cycle can take a beat
   assign busy     = 1'b0;
   assign hdr_take = start && !busy;

   assign hdr.seg_type    = req_seg_type;
   assign hdr.perm_flags  = req_perm_flags;
   assign hdr.file_offset = req_file_offset;
   assign hdr.file_bytes  = req_file_bytes;
   assign hdr.virt_addr   = req_virt_addr;
   assign hdr.mem_bytes   = req_mem_bytes;
   assign hdr.align_bytes = req_align_bytes;

   phv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .image_size  (image_size_reg)
   );

   // stage 1: flags, truncation, raw compares
   phv_front #(
      .PAGE_BYTES (PAGE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (hdr_take),
      .hdr        (hdr),
      .image_size (image_size_reg),
      .out_valid  (s1_valid),
      .out_beat   (s1_beat)
   );

   // stage 2: extent, range, whole space, alignment shape
   phv_mid #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_beat   (s1_beat),
      .out_valid (s2_valid),
      .out_beat  (s2_beat)
   );

   // stage 3: rounded truncation, misalignment, first-fault pick
   phv_resolve u_resolve (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_beat        (s2_beat),
      .image_size     (image_size_reg),
      .rsp_valid      (rsp_valid),
      .rsp_is_valid   (rsp_is_valid),
      .rsp_fault_code (rsp_fault_code)
   );

endmodule

[src/phv_csr.sv]
// ----------------------------------------------------------------------------
// phv_csr - configuration register file
// APB-style slave holding the 64-bit image size register.
// ----------------------------------------------------------------------------
module phv_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [phv_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [phv_pkg::WORD_W-1:0]        csr_pwdata,
   output logic [phv_pkg::WORD_W-1:0]        csr_prdata,
   output logic                              csr_pready,
   output logic [phv_pkg::WORD_W-1:0]        image_size
);

   logic [phv_pkg::WORD_W-1:0] image_size_ff;
   logic [phv_pkg::WORD_W-1:0] image_size_in;
   logic                       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == phv_pkg::CSR_IMAGE_SIZE_ADDR);

   always_comb begin
      image_size_in = image_size_ff;
      if (wr_hit) begin
         image_size_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
      end else begin
         image_size_ff <= image_size_in;
      end
   end

   // unmapped offsets read as zero
   assign csr_prdata = (csr_paddr == phv_pkg::CSR_IMAGE_SIZE_ADDR) ? image_size_ff : '0;
   assign image_size = image_size_ff;

endmodule

[src/phv_front.sv]
// ----------------------------------------------------------------------------
// phv_front - pipeline stage 1
// Flag and truncation checks; the independent compares and subtracts that
// later stages combine.
// ----------------------------------------------------------------------------
module phv_front #(
   parameter int PAGE_BYTES = 4096,
   parameter int ADDR_BITS  = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  phv_pkg::phv_hdr_type        hdr,
   input  logic [phv_pkg::WORD_W-1:0]  image_size,
   output logic                        out_valid,
   output phv_pkg::phv_front_type      out_beat
);

   localparam logic [phv_pkg::WORD_W-1:0] PAGE     = phv_pkg::WORD_W'(PAGE_BYTES);
   localparam logic [phv_pkg::WORD_W-1:0] ADDR_TOP =
      {phv_pkg::WORD_W{1'b1}} >> (phv_pkg::WORD_W - ADDR_BITS);
   localparam logic [phv_pkg::WORD_W-1:0] PAGE_LIM = ADDR_TOP - PAGE + 1'b1;

   logic                   valid_ff;
   phv_pkg::phv_front_type beat_ff;
   phv_pkg::phv_front_type beat_in;
   logic                   fsz_nz;
   logic                   flag_r;
   logic                   flag_w;

   always_comb begin
      fsz_nz = (hdr.file_bytes != '0);
      flag_r = hdr.perm_flags[phv_pkg::PF_R];
      flag_w = hdr.perm_flags[phv_pkg::PF_W];

      // anything beyond X/W/R is unknown
      beat_in.flags_bad     = (hdr.perm_flags[phv_pkg::FIELD_W-1:phv_pkg::PF_R+1] != '0);
      beat_in.truncated     = (image_size < hdr.file_offset) ||
                              (image_size < hdr.file_bytes);
      beat_in.off_gt_lim    = (hdr.file_offset > PAGE_LIM);
      beat_in.lim_minus_off = PAGE_LIM - hdr.file_offset;
      beat_in.file_bytes    = hdr.file_bytes;
      beat_in.end_sum       = hdr.file_offset + hdr.file_bytes;
      beat_in.msz_nz        = (hdr.mem_bytes != '0);
      beat_in.msz_gt_top    = (hdr.mem_bytes > ADDR_TOP);
      beat_in.va_gt_top     = (hdr.virt_addr > ADDR_TOP);
      beat_in.top_minus_msz = ADDR_TOP - (hdr.mem_bytes - 1'b1);
      beat_in.va_lt_page    = (hdr.virt_addr < PAGE);
      beat_in.lim_minus_va  = PAGE_LIM - hdr.virt_addr;
      beat_in.mem_bytes     = hdr.mem_bytes;
      beat_in.msz_lt_fsz    = (hdr.mem_bytes < hdr.file_bytes);
      beat_in.unreadable    = !flag_r && fsz_nz;
      // read-only load segment with partial memory image; page test comes later
      beat_in.ro_load_part  = (hdr.seg_type == phv_pkg::PT_LOAD) && fsz_nz && !flag_w &&
                              (hdr.file_bytes != hdr.mem_bytes);
      beat_in.virt_addr     = hdr.virt_addr;
      beat_in.va_xor_off    = hdr.virt_addr ^ hdr.file_offset;
      beat_in.align_eff     = (hdr.align_bytes > PAGE) ? hdr.align_bytes : PAGE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

[src/phv_mid.sv]
// ----------------------------------------------------------------------------
// phv_mid - pipeline stage 2
// Extent overflow, page rounding, range, whole-space and page-end checks,
// alignment power-of-two test.
// ----------------------------------------------------------------------------
module phv_mid #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  phv_pkg::phv_front_type      in_beat,
   output logic                        out_valid,
   output phv_pkg::phv_mid_type        out_beat
);

   localparam logic [phv_pkg::WORD_W-1:0] PAGE_MASK = phv_pkg::WORD_W'(PAGE_BYTES - 1);

   logic                       valid_ff;
   phv_pkg::phv_mid_type       beat_ff;
   phv_pkg::phv_mid_type       beat_in;
   logic [phv_pkg::WORD_W-1:0] align_m1;

   always_comb begin
      align_m1 = in_beat.align_eff - 1'b1;

      beat_in.flags_bad   = in_beat.flags_bad;
      beat_in.truncated   = in_beat.truncated;
      beat_in.ext_ovf     = in_beat.off_gt_lim || (in_beat.file_bytes > in_beat.lim_minus_off);
      // no wrap here once the extent check passed
      beat_in.rounded     = (in_beat.end_sum + PAGE_MASK) & ~PAGE_MASK;
      beat_in.range_bad   = in_beat.msz_nz &&
                            (in_beat.msz_gt_top || in_beat.va_gt_top ||
                             (in_beat.top_minus_msz < in_beat.virt_addr));
      beat_in.whole_space = in_beat.msz_nz && in_beat.va_lt_page &&
                            (in_beat.mem_bytes > in_beat.lim_minus_va);
      beat_in.msz_lt_fsz  = in_beat.msz_lt_fsz;
      beat_in.unreadable  = in_beat.unreadable;
      beat_in.page_end    = in_beat.ro_load_part && ((in_beat.end_sum & PAGE_MASK) != '0);
      beat_in.align_bad   = ((in_beat.align_eff & align_m1) != '0);
      beat_in.va_xor_off  = in_beat.va_xor_off;
      beat_in.align_mask  = align_m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

[src/phv_resolve.sv]
// ----------------------------------------------------------------------------
// phv_resolve - pipeline stage 3
// Page-rounded truncation and offset alignment checks, then first-fault
// priority pick into the result register.
// ----------------------------------------------------------------------------
module phv_resolve (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  phv_pkg::phv_mid_type              in_beat,
   input  logic [phv_pkg::WORD_W-1:0]        image_size,
   output logic                              rsp_valid,
   output logic                              rsp_is_valid,
   output logic [phv_pkg::CODE_W-1:0]        rsp_fault_code
);

   logic                        valid_ff;
   logic [phv_pkg::CODE_W-1:0]  code_ff;
   logic [phv_pkg::CODE_W-1:0]  code_in;
   logic                        page_trunc;
   logic                        misaligned;

   always_comb begin
      page_trunc = (image_size < in_beat.rounded);
      misaligned = ((in_beat.va_xor_off & in_beat.align_mask) != '0);

      if (in_beat.flags_bad) begin
         code_in = phv_pkg::FAULT_FLAGS;
      end else if (in_beat.truncated) begin
         code_in = phv_pkg::FAULT_TRUNCATED;
      end else if (in_beat.ext_ovf) begin
         code_in = phv_pkg::FAULT_EXT_OVF;
      end else if (page_trunc) begin
         code_in = phv_pkg::FAULT_PAGE_TRUNC;
      end else if (in_beat.range_bad) begin
         code_in = phv_pkg::FAULT_RANGE;
      end else if (in_beat.whole_space) begin
         code_in = phv_pkg::FAULT_WHOLE_SPACE;
      end else if (in_beat.msz_lt_fsz) begin
         code_in = phv_pkg::FAULT_MEM_SHORT;
      end else if (in_beat.unreadable) begin
         code_in = phv_pkg::FAULT_UNREADABLE;
      end else if (in_beat.page_end) begin
         code_in = phv_pkg::FAULT_PAGE_END;
      end else if (in_beat.align_bad) begin
         code_in = phv_pkg::FAULT_ALIGN;
      end else if (misaligned) begin
         code_in = phv_pkg::FAULT_MISALIGNED;
      end else begin
         code_in = phv_pkg::FAULT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_fault_code = code_ff;
   assign rsp_is_valid   = (code_ff == phv_pkg::FAULT_NONE);

endmodule
